@@ design/ddn_pkg.sv @@
// types, constants and codes shared by the detector decode and suppression block
// no dependencies
package ddn_pkg;

   localparam int MAX_KEPT    = 64;
   localparam int KEPT_AW     = $clog2(MAX_KEPT);
   localparam int COUNT_W     = KEPT_AW + 1;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int MUL_A_W     = 18;
   localparam int MUL_B_W     = 33;
   localparam int PROD_W      = MUL_A_W + MUL_B_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PAD_LEFT      = 3'd0,
      CSR_PAD_TOP       = 3'd1,
      CSR_INV_SCALE     = 3'd2,
      CSR_IMAGE_WIDTH   = 3'd3,
      CSR_IMAGE_HEIGHT  = 3'd4,
      CSR_SCORE_THRESH  = 3'd5,
      CSR_OVERLAP_THRESH = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [15:0] center_x;
      logic [15:0] center_y;
      logic [15:0] box_width;
      logic [15:0] box_height;
      logic [15:0] class_score;
      logic [7:0]  class_index;
      logic        last_class;
      logic        last_anchor;
   } req_type;

   typedef struct packed {
      logic        valid_res;
      logic [15:0] left;
      logic [15:0] top;
      logic [15:0] right;
      logic [15:0] bottom;
      logic [15:0] confidence;
      logic [7:0]  class_num;
      logic        last;
      logic        overflow;
   } rsp_type;

   typedef struct packed {
      logic [15:0] left;
      logic [15:0] top;
      logic [15:0] right;
      logic [15:0] bottom;
      logic [15:0] score;
      logic [7:0]  class_num;
   } entry_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DEC_MUL,
      ST_DEC_FIN,
      ST_INS_START,
      ST_INS_FULL,
      ST_INS_STEP,
      ST_INS_SHIFT,
      ST_NMS_I,
      ST_NMS_A,
      ST_NMS_AREA,
      ST_NMS_J,
      ST_NMS_B,
      ST_NMS_C,
      ST_NMS_D,
      ST_NMS_E,
      ST_NMS_F,
      ST_FIND,
      ST_EMIT_I,
      ST_EMIT_LD,
      ST_OUT
   } state_type;

endpackage

@@ design/detector_decode_and_nms_top.sv @@
// detector back end: per-anchor argmax, letterbox decode, sorted store,
// greedy same-class suppression and result emission; uses ddn_pkg
//
// usage: one request per class score, each repeating the anchor box.
// last_class ends an anchor, last_anchor ends the frame (and its anchor).
// req_stall is low only while the block is idle. an anchor end whose best
// score meets the threshold is decoded edge by edge through the one shared
// multiplier (ST_DEC_MUL then ST_DEC_FIN per edge), then sorted into the
// store, each entry moved during the sorted insert taking one store read and
// one store write. at frame end suppression visits each pair of same-class
// survivors, with areas and overlap tests all through the same multiplier.
// results then leave one at a time from an output register; rsp_valid holds
// with a steady payload while rsp_stall is high. an empty frame gives one
// marker with valid_res low. the final result of a frame carries last.
// synchronous reset clears the anchor state, the store count, the drop
// marks and the overflow flag and loads the register defaults; no clearing
// pass is needed.
module detector_decode_and_nms_top
   import ddn_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   // configuration
   logic [11:0] pad_left_ff, pad_top_ff, image_width_ff, image_height_ff;
   logic [15:0] inv_scale_ff, score_thresh_ff, overlap_thresh_ff;

   state_type state_ff, state_in;
   logic [15:0] top_score_ff, top_score_in;
   logic [7:0]  top_class_ff, top_class_in;
   logic [15:0] cx_ff, cx_in, cy_ff, cy_in, bw_ff, bw_in, bh_ff, bh_in;
   logic        frame_end_ff, frame_end_in;
   logic [1:0]  edge_ff, edge_in;
   logic [15:0] edges_ff [4];
   logic [15:0] edge_val;
   logic        edge_we;
   logic [COUNT_W-1:0] count_ff, count_in, pos_ff, pos_in;
   logic [COUNT_W-1:0] i_ff, i_in, j_ff, j_in, last_idx_ff, last_idx_in;
   logic        any_ff, any_in;
   logic        overflow_ff, overflow_in;
   logic [MAX_KEPT-1:0] drop_ff, drop_in;
   entry_type   a_ff, a_in, c_ff, c_in;
   logic [31:0] area_a_ff, area_a_in, inter_ff, inter_in;
   logic [32:0] uni_ff, uni_in;
   logic [PROD_W-1:0] prod_ff;
   logic [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0] mul_b;
   rsp_type     rsp_ff, rsp_in;

   // store memory
   entry_type   store_mem [MAX_KEPT];
   entry_type   rd_ff, mem_wdata, cand;
   logic        mem_we, mem_re;
   logic [KEPT_AW-1:0] mem_waddr, mem_raddr;

   // argmax against the incoming request
   logic        take_new;
   logic [15:0] nb_score;
   logic [7:0]  nb_class;

   // decode
   logic [15:0] dc, ds;
   logic [11:0] dpad, dlim;
   logic        dplus;
   logic signed [19:0] v;
   logic        v_pos;
   logic [20:0] q;
   logic [15:0] lim16;

   // overlap
   logic [15:0] ix1, iy1, ix2, iy2, iw, ih;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_data  = rsp_ff;

   assign take_new = (req_data.class_score > top_score_ff);
   assign nb_score = take_new ? req_data.class_score : top_score_ff;
   assign nb_class = take_new ? req_data.class_index : top_class_ff;

   assign cand = '{left: edges_ff[0], top: edges_ff[1], right: edges_ff[2],
                   bottom: edges_ff[3], score: top_score_ff, class_num: top_class_ff};

   always_comb begin
      case (edge_ff)
         2'd0: begin
            dc = cx_ff; ds = bw_ff; dpad = pad_left_ff; dlim = image_width_ff; dplus = 1'b0;
         end
         2'd1: begin
            dc = cy_ff; ds = bh_ff; dpad = pad_top_ff; dlim = image_height_ff; dplus = 1'b0;
         end
         2'd2: begin
            dc = cx_ff; ds = bw_ff; dpad = pad_left_ff; dlim = image_width_ff; dplus = 1'b1;
         end
         default: begin
            dc = cy_ff; ds = bh_ff; dpad = pad_top_ff; dlim = image_height_ff; dplus = 1'b1;
         end
      endcase
   end

   // edge in signed Q14.5 (20 bits) before scaling
   assign v = $signed({3'b000, dc, 1'b0})
            + (dplus ? $signed({4'b0000, ds}) : -$signed({4'b0000, ds}))
            - $signed({3'b000, dpad, 5'b00000});
   assign v_pos = !v[19] && (v != 20'sd0);
   assign q     = 21'((prod_ff + PROD_W'(4096)) >> 13);
   assign lim16 = {dlim, 4'b0000};
   assign edge_val = !v_pos ? 16'd0 : ((q > {5'b00000, lim16}) ? lim16 : q[15:0]);

   assign ix1 = (a_ff.left   > rd_ff.left)   ? a_ff.left   : rd_ff.left;
   assign iy1 = (a_ff.top    > rd_ff.top)    ? a_ff.top    : rd_ff.top;
   assign ix2 = (a_ff.right  < rd_ff.right)  ? a_ff.right  : rd_ff.right;
   assign iy2 = (a_ff.bottom < rd_ff.bottom) ? a_ff.bottom : rd_ff.bottom;
   assign iw  = (ix2 > ix1) ? 16'(ix2 - ix1) : 16'd0;
   assign ih  = (iy2 > iy1) ? 16'(iy2 - iy1) : 16'd0;

   // shared multiplier operands
   always_comb begin
      case (state_ff)
         ST_DEC_MUL: begin
            mul_a = v[MUL_A_W-1:0];
            mul_b = {17'd0, inv_scale_ff};
         end
         ST_NMS_A: begin
            mul_a = {2'b00, 16'(rd_ff.right - rd_ff.left)};
            mul_b = {17'd0, 16'(rd_ff.bottom - rd_ff.top)};
         end
         ST_NMS_B: begin
            mul_a = {2'b00, iw};
            mul_b = {17'd0, ih};
         end
         ST_NMS_C: begin
            mul_a = {2'b00, 16'(c_ff.right - c_ff.left)};
            mul_b = {17'd0, 16'(c_ff.bottom - c_ff.top)};
         end
         ST_NMS_E: begin
            mul_a = {2'b00, overlap_thresh_ff};
            mul_b = uni_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      top_score_in  = top_score_ff;
      top_class_in  = top_class_ff;
      cx_in = cx_ff; cy_in = cy_ff; bw_in = bw_ff; bh_in = bh_ff;
      frame_end_in  = frame_end_ff;
      edge_in       = edge_ff;
      edge_we       = 1'b0;
      count_in      = count_ff;
      pos_in        = pos_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      last_idx_in   = last_idx_ff;
      any_in        = any_ff;
      overflow_in   = overflow_ff;
      drop_in       = drop_ff;
      a_in          = a_ff;
      c_in          = c_ff;
      area_a_in     = area_a_ff;
      inter_in      = inter_ff;
      uni_in        = uni_ff;
      rsp_in        = rsp_ff;
      mem_we        = 1'b0;
      mem_waddr     = pos_ff[KEPT_AW-1:0];
      mem_wdata     = cand;
      mem_re        = 1'b0;
      mem_raddr     = i_ff[KEPT_AW-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cx_in = req_data.center_x;
               cy_in = req_data.center_y;
               bw_in = req_data.box_width;
               bh_in = req_data.box_height;
               top_score_in = nb_score;
               top_class_in = nb_class;
               frame_end_in  = req_data.last_anchor;
               if (req_data.last_class || req_data.last_anchor) begin
                  if (nb_score >= score_thresh_ff) begin
                     edge_in  = 2'd0;
                     state_in = ST_DEC_MUL;
                  end else begin
                     top_score_in = '0;
                     top_class_in = '0;
                     if (req_data.last_anchor) begin
                        i_in     = '0;
                        state_in = ST_NMS_I;
                     end
                  end
               end
            end
         end
         ST_DEC_MUL: state_in = ST_DEC_FIN;
         ST_DEC_FIN: begin
            edge_we = 1'b1;
            if (edge_ff == 2'd3) begin
               state_in = ST_INS_START;
            end else begin
               edge_in  = 2'(edge_ff + 2'd1);
               state_in = ST_DEC_MUL;
            end
         end
         ST_INS_START: begin
            if (count_ff == COUNT_W'(MAX_KEPT)) begin
               mem_re    = 1'b1;
               mem_raddr = KEPT_AW'(MAX_KEPT - 1);
               state_in  = ST_INS_FULL;
            end else begin
               pos_in   = count_ff;
               state_in = ST_INS_STEP;
            end
         end
         ST_INS_FULL: begin
            overflow_in = 1'b1;
            if (top_score_ff <= rd_ff.score) begin
               // candidate loses to the lowest entry, tie keeps the older one
               top_score_in = '0;
               top_class_in = '0;
               i_in          = '0;
               state_in      = frame_end_ff ? ST_NMS_I : ST_IDLE;
            end else begin
               count_in = COUNT_W'(MAX_KEPT - 1);
               pos_in   = COUNT_W'(MAX_KEPT - 1);
               state_in = ST_INS_STEP;
            end
         end
         ST_INS_STEP: begin
            if (pos_ff == '0) begin
               mem_we        = 1'b1;
               count_in      = COUNT_W'(count_ff + 1'b1);
               top_score_in = '0;
               top_class_in = '0;
               i_in          = '0;
               state_in      = frame_end_ff ? ST_NMS_I : ST_IDLE;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = KEPT_AW'(pos_ff - 1'b1);
               state_in  = ST_INS_SHIFT;
            end
         end
         ST_INS_SHIFT: begin
            mem_we = 1'b1;
            if (rd_ff.score < top_score_ff) begin
               mem_wdata = rd_ff;
               pos_in    = COUNT_W'(pos_ff - 1'b1);
               state_in  = ST_INS_STEP;
            end else begin
               count_in      = COUNT_W'(count_ff + 1'b1);
               top_score_in = '0;
               top_class_in = '0;
               i_in          = '0;
               state_in      = frame_end_ff ? ST_NMS_I : ST_IDLE;
            end
         end
         ST_NMS_I: begin
            if (i_ff >= count_ff) begin
               pos_in   = count_ff;
               any_in   = 1'b0;
               state_in = ST_FIND;
            end else if (drop_ff[i_ff[KEPT_AW-1:0]]) begin
               i_in = COUNT_W'(i_ff + 1'b1);
            end else begin
               mem_re   = 1'b1;
               state_in = ST_NMS_A;
            end
         end
         ST_NMS_A: begin
            a_in     = rd_ff;
            state_in = ST_NMS_AREA;
         end
         ST_NMS_AREA: begin
            area_a_in = prod_ff[31:0];
            j_in      = COUNT_W'(i_ff + 1'b1);
            state_in  = ST_NMS_J;
         end
         ST_NMS_J: begin
            if (j_ff >= count_ff) begin
               i_in     = COUNT_W'(i_ff + 1'b1);
               state_in = ST_NMS_I;
            end else if (drop_ff[j_ff[KEPT_AW-1:0]]) begin
               j_in = COUNT_W'(j_ff + 1'b1);
            end else begin
               mem_re    = 1'b1;
               mem_raddr = j_ff[KEPT_AW-1:0];
               state_in  = ST_NMS_B;
            end
         end
         ST_NMS_B: begin
            c_in = rd_ff;
            if (rd_ff.class_num != a_ff.class_num) begin
               j_in     = COUNT_W'(j_ff + 1'b1);
               state_in = ST_NMS_J;
            end else begin
               state_in = ST_NMS_C;
            end
         end
         ST_NMS_C: begin
            inter_in = prod_ff[31:0];
            state_in = ST_NMS_D;
         end
         ST_NMS_D: begin
            uni_in   = 33'({1'b0, area_a_ff} + {1'b0, prod_ff[31:0]} - {1'b0, inter_ff});
            state_in = ST_NMS_E;
         end
         ST_NMS_E: state_in = ST_NMS_F;
         ST_NMS_F: begin
            // inter / union > thr / 65536 without a divide
            if ((uni_ff != '0) && ({3'b000, inter_ff, 16'h0000} > prod_ff))
               drop_in[j_ff[KEPT_AW-1:0]] = 1'b1;
            j_in     = COUNT_W'(j_ff + 1'b1);
            state_in = ST_NMS_J;
         end
         ST_FIND: begin
            // locate the final survivor so it can carry last
            i_in = '0;
            if (pos_ff == '0) begin
               state_in = ST_EMIT_I;
            end else if (!drop_ff[KEPT_AW'(pos_ff - 1'b1)]) begin
               last_idx_in = COUNT_W'(pos_ff - 1'b1);
               any_in      = 1'b1;
               state_in    = ST_EMIT_I;
            end else begin
               pos_in = COUNT_W'(pos_ff - 1'b1);
            end
         end
         ST_EMIT_I: begin
            if (!any_ff) begin
               rsp_in          = '0;
               rsp_in.last     = 1'b1;
               rsp_in.overflow = overflow_ff;
               state_in        = ST_OUT;
            end else if (drop_ff[i_ff[KEPT_AW-1:0]]) begin
               i_in = COUNT_W'(i_ff + 1'b1);
            end else begin
               mem_re   = 1'b1;
               state_in = ST_EMIT_LD;
            end
         end
         ST_EMIT_LD: begin
            rsp_in.valid_res  = 1'b1;
            rsp_in.left       = rd_ff.left;
            rsp_in.top        = rd_ff.top;
            rsp_in.right      = rd_ff.right;
            rsp_in.bottom     = rd_ff.bottom;
            rsp_in.confidence = rd_ff.score;
            rsp_in.class_num  = rd_ff.class_num;
            rsp_in.last       = (i_ff == last_idx_ff);
            rsp_in.overflow   = overflow_ff;
            state_in          = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               if (rsp_ff.last) begin
                  count_in      = '0;
                  overflow_in   = 1'b0;
                  drop_in       = '0;
                  frame_end_in  = 1'b0;
                  top_score_in = '0;
                  top_class_in = '0;
                  state_in      = ST_IDLE;
               end else begin
                  i_in     = COUNT_W'(i_ff + 1'b1);
                  state_in = ST_EMIT_I;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         top_score_ff      <= '0;
         top_class_ff      <= '0;
         frame_end_ff      <= 1'b0;
         count_ff          <= '0;
         overflow_ff       <= 1'b0;
         drop_ff           <= '0;
         pad_left_ff       <= 12'd0;
         pad_top_ff        <= 12'd0;
         inv_scale_ff      <= 16'd4096;
         image_width_ff    <= 12'd640;
         image_height_ff   <= 12'd640;
         score_thresh_ff   <= 16'd16384;
         overlap_thresh_ff <= 16'd29491;
      end else begin
         state_ff      <= state_in;
         top_score_ff  <= top_score_in;
         top_class_ff  <= top_class_in;
         frame_end_ff  <= frame_end_in;
         count_ff      <= count_in;
         overflow_ff   <= overflow_in;
         drop_ff       <= drop_in;
         if (csr_wr_en) begin
            case (csr_index)
               CSR_PAD_LEFT:       pad_left_ff       <= csr_wr_data[11:0];
               CSR_PAD_TOP:        pad_top_ff        <= csr_wr_data[11:0];
               CSR_INV_SCALE:      inv_scale_ff      <= csr_wr_data;
               CSR_IMAGE_WIDTH:    image_width_ff    <= csr_wr_data[11:0];
               CSR_IMAGE_HEIGHT:   image_height_ff   <= csr_wr_data[11:0];
               CSR_SCORE_THRESH:   score_thresh_ff   <= csr_wr_data;
               CSR_OVERLAP_THRESH: overlap_thresh_ff <= csr_wr_data;
               default: ;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      bw_ff       <= bw_in;
      bh_ff       <= bh_in;
      edge_ff     <= edge_in;
      pos_ff      <= pos_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      last_idx_ff <= last_idx_in;
      any_ff      <= any_in;
      a_ff        <= a_in;
      c_ff        <= c_in;
      area_a_ff   <= area_a_in;
      inter_ff    <= inter_in;
      uni_ff      <= uni_in;
      rsp_ff      <= rsp_in;
      prod_ff     <= PROD_W'(mul_a) * PROD_W'(mul_b);
      if (edge_we)
         edges_ff[edge_ff] <= edge_val;
   end

   always_ff @(posedge clock) begin
      if (mem_we)
         store_mem[mem_waddr] <= mem_wdata;
      if (mem_re)
         rd_ff <= store_mem[mem_raddr];
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(MAX_KEPT))
      else $error("store count beyond capacity");

   a_marker_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.valid_res) |-> rsp_data.last)
      else $error("empty frame marker without last");

   a_frame_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_data.last) |=>
         (count_ff == '0 && !overflow_ff && drop_ff == '0 && !req_stall))
      else $error("frame state not cleared after final result");

endmodule

@@ bench/tb_top.sv @@
// testbench for detector_decode_and_nms_top: streams class-score requests,
// predicts the detections of each frame and checks them; uses ddn_pkg
`timescale 1ns / 100ps

module tb_top;
   import ddn_pkg::*;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_type req_data;
   logic rsp_valid;
   logic rsp_stall;
   rsp_type rsp_data;
   logic csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   detector_decode_and_nms_top u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data)
   );

   // register copies
   int unsigned pad_x, pad_y, inv_scale, img_w, img_h, score_min, overlap_min;
   // per-anchor and per-frame state of the predictor
   logic [15:0] anchor_score;
   logic [7:0] anchor_class;
   req_type held_box;
   entry_type kept [MAX_KEPT];
   bit dropped [MAX_KEPT];
   int kept_n;
   bit evicted;

   rsp_type detections [$];
   int errors;
   int frames;
   int results_seen;
   int requests_sent;
   bit quiet;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10ms;
      $display("tb_top failed");
      $finish;
   end

   task automatic report(string what, longint got, longint want);
      errors++;
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
   endtask

   function automatic logic [15:0] map_edge(longint v, int unsigned limit_px);
      longint q;
      longint lim;
      lim = longint'(limit_px) * 16;
      if (v <= 0) return 16'd0;
      q = (v * longint'(inv_scale) + 4096) >>> 13;
      return (q > lim) ? lim[15:0] : q[15:0];
   endfunction

   function automatic void insert_box(entry_type e);
      int pos;
      if (kept_n >= MAX_KEPT) begin
         evicted = 1'b1;
         if (e.score <= kept[MAX_KEPT-1].score) return;
         kept_n = MAX_KEPT - 1;
      end
      pos = kept_n;
      while (pos > 0 && kept[pos-1].score < e.score) pos--;
      for (int k = kept_n; k > pos; k--) kept[k] = kept[k-1];
      kept[pos] = e;
      kept_n++;
   endfunction

   function automatic void close_anchor();
      longint cx, cy, w, h, px, py;
      entry_type e;
      cx = held_box.center_x; cy = held_box.center_y;
      w = held_box.box_width; h = held_box.box_height;
      px = longint'(pad_x) * 32; py = longint'(pad_y) * 32;
      if (anchor_score >= score_min) begin
         e.left = map_edge(2*cx - w - px, img_w);
         e.top = map_edge(2*cy - h - py, img_h);
         e.right = map_edge(2*cx + w - px, img_w);
         e.bottom = map_edge(2*cy + h - py, img_h);
         e.score = anchor_score;
         e.class_num = anchor_class;
         insert_box(e);
      end
      anchor_score = '0; anchor_class = '0; held_box = '0;
   endfunction

   function automatic longint unsigned area(entry_type e);
      return longint'(e.right - e.left) * longint'(e.bottom - e.top);
   endfunction

   function automatic void suppress_overlaps();
      longint unsigned ix1, iy1, ix2, iy2, inter, uni;
      for (int i = 0; i < kept_n; i++) begin
         if (dropped[i]) continue;
         for (int j = i + 1; j < kept_n; j++) begin
            if (dropped[j] || kept[i].class_num != kept[j].class_num) continue;
            ix1 = (kept[i].left > kept[j].left) ? kept[i].left : kept[j].left;
            iy1 = (kept[i].top > kept[j].top) ? kept[i].top : kept[j].top;
            ix2 = (kept[i].right < kept[j].right) ? kept[i].right : kept[j].right;
            iy2 = (kept[i].bottom < kept[j].bottom) ? kept[i].bottom : kept[j].bottom;
            inter = ((ix2 > ix1) ? ix2 - ix1 : 0) * ((iy2 > iy1) ? iy2 - iy1 : 0);
            uni = area(kept[i]) + area(kept[j]) - inter;
            if (uni > 0 && inter * 65536 > longint'(overlap_min) * uni) dropped[j] = 1'b1;
         end
      end
   endfunction

   // work out the detections a request causes and queue them
   function automatic void predict_detections(req_type r);
      rsp_type d;
      int n;
      held_box = r;
      if (r.class_score > anchor_score) begin
         anchor_score = r.class_score;
         anchor_class = r.class_index;
      end
      if (r.last_class || r.last_anchor) close_anchor();
      if (!r.last_anchor) return;
      suppress_overlaps();
      n = 0;
      for (int i = 0; i < kept_n; i++) begin
         if (dropped[i]) continue;
         d = '0;
         d.valid_res = 1'b1;
         d.left = kept[i].left; d.top = kept[i].top;
         d.right = kept[i].right; d.bottom = kept[i].bottom;
         d.confidence = kept[i].score; d.class_num = kept[i].class_num;
         d.overflow = evicted;
         detections.insert(detections.size(), d);
         n++;
      end
      if (n == 0) begin
         d = '0;
         d.overflow = evicted;
         detections.insert(detections.size(), d);
      end
      detections[detections.size()-1].last = 1'b1;
      for (int k = 0; k < MAX_KEPT; k++) dropped[k] = 1'b0;
      kept_n = 0;
      evicted = 1'b0;
      frames++;
   endfunction

   // result checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (detections.size() == 0) begin
            report("unexpected result", rsp_data.confidence, 0);
         end else begin
            want = detections.pop_front();
            if (rsp_data.valid_res != want.valid_res)
               report("valid_res", rsp_data.valid_res, want.valid_res);
            if (rsp_data.left != want.left) report("left", rsp_data.left, want.left);
            if (rsp_data.top != want.top) report("top", rsp_data.top, want.top);
            if (rsp_data.right != want.right) report("right", rsp_data.right, want.right);
            if (rsp_data.bottom != want.bottom)
               report("bottom", rsp_data.bottom, want.bottom);
            if (rsp_data.confidence != want.confidence)
               report("confidence", rsp_data.confidence, want.confidence);
            if (rsp_data.class_num != want.class_num)
               report("class_num", rsp_data.class_num, want.class_num);
            if (rsp_data.last != want.last) report("last", rsp_data.last, want.last);
            if (rsp_data.overflow != want.overflow)
               report("overflow", rsp_data.overflow, want.overflow);
         end
      end
   end

   // receiver backpressure in random bursts
   int stall_left;
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 18);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic send_request(req_type r);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      predict_detections(r);
      requests_sent++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (detections.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, int unsigned value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= value[15:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_PAD_LEFT: pad_x = value & 12'hfff;
         CSR_PAD_TOP: pad_y = value & 12'hfff;
         CSR_INV_SCALE: inv_scale = value & 16'hffff;
         CSR_IMAGE_WIDTH: img_w = value & 12'hfff;
         CSR_IMAGE_HEIGHT: img_h = value & 12'hfff;
         CSR_SCORE_THRESH: score_min = value & 16'hffff;
         CSR_OVERLAP_THRESH: overlap_min = value & 16'hffff;
         default: ;
      endcase
   endtask

   task automatic write_all(int unsigned pl, int unsigned pt, int unsigned inv,
                            int unsigned iw, int unsigned ih, int unsigned st,
                            int unsigned ot);
      wait_idle();
      write_reg(CSR_PAD_LEFT, pl);
      write_reg(CSR_PAD_TOP, pt);
      write_reg(CSR_INV_SCALE, inv);
      write_reg(CSR_IMAGE_WIDTH, iw);
      write_reg(CSR_IMAGE_HEIGHT, ih);
      write_reg(CSR_SCORE_THRESH, st);
      write_reg(CSR_OVERLAP_THRESH, ot);
   endtask

   function automatic req_type make_request(int cx, int cy, int w, int h, int s, int c,
                                            bit lc, bit la);
      req_type r;
      r.center_x = 16'(cx); r.center_y = 16'(cy);
      r.box_width = 16'(w); r.box_height = 16'(h);
      r.class_score = 16'(s); r.class_index = 8'(c);
      r.last_class = lc; r.last_anchor = la;
      return r;
   endfunction

   // defaults: ties in argmax, same-class overlap, frame end mid-anchor
   task automatic test_defaults();
      send_request(make_request(3200, 3200, 800, 800, 100, 0, 0, 0));
      send_request(make_request(3200, 3200, 800, 800, 40000, 1, 0, 0));
      // equal score must not replace the earlier class
      send_request(make_request(3210, 3190, 820, 790, 40000, 2, 1, 0));
      send_request(make_request(3220, 3200, 800, 800, 50000, 1, 1, 0));
      send_request(make_request(1000, 1000, 100, 100, 16383, 5, 1, 0));
      // all-zero scores keep class 0 at score 0
      send_request(make_request(500, 500, 200, 200, 0, 0, 1, 0));
      send_request(make_request(65535, 65535, 65535, 65535, 65535, 255, 0, 1));
      send_request(make_request(0, 0, 0, 0, 16384, 3, 1, 1));
   endtask

   task automatic test_empty_frame();
      send_request(make_request(2000, 2000, 300, 300, 1, 7, 1, 0));
      send_request(make_request(2000, 2000, 300, 300, 2, 7, 0, 1));
   endtask

   task automatic test_register_extremes();
      write_all(4095, 4095, 65535, 4095, 4095, 0, 0);
      send_request(make_request(65535, 65535, 100, 65535, 0, 0, 1, 0));
      send_request(make_request(65535, 65530, 120, 65535, 9, 0, 1, 0));
      send_request(make_request(0, 65535, 65535, 0, 65535, 128, 0, 1));
      write_all(0, 0, 0, 1, 1, 65535, 65535);
      send_request(make_request(1234, 4321, 50, 60, 65535, 4, 1, 0));
      send_request(make_request(1234, 4321, 50, 60, 65535, 4, 1, 0));
      send_request(make_request(100, 100, 10, 10, 65534, 4, 1, 1));
      write_all(0, 0, 4096, 640, 640, 16384, 29491);
   endtask

   // more candidates than the store holds, with ties at the bottom
   task automatic test_store_overflow();
      for (int a = 0; a < 72; a++)
         send_request(make_request($urandom_range(0, 10240), $urandom_range(0, 10240),
                                   $urandom_range(16, 800), $urandom_range(16, 800),
                                   20000 + 100 * $urandom_range(0, 20),
                                   $urandom_range(0, 255), 1, a == 71));
   endtask

   task automatic random_frame(int anchors, ref int budget);
      int cx, cy, w, h, ncls, cls_hi;
      bit wild;
      cx = $urandom_range(0, 10240); cy = $urandom_range(0, 10240);
      w = $urandom_range(16, 2000); h = $urandom_range(16, 2000);
      cls_hi = $urandom_range(0, 3) == 0 ? 255 : 3;
      for (int a = 0; a < anchors; a++) begin
         wild = $urandom_range(0, 3) == 0;
         // neighbors of the previous box make overlaps likely
         if (wild) begin
            cx = $urandom_range(0, 65535); cy = $urandom_range(0, 65535);
            w = $urandom_range(0, 65535); h = $urandom_range(0, 65535);
         end else if ($urandom_range(0, 2) == 0) begin
            cx = $urandom_range(0, 10240); cy = $urandom_range(0, 10240);
            w = $urandom_range(16, 2000); h = $urandom_range(16, 2000);
         end else begin
            cx = (cx + $urandom_range(0, 64)) & 16'hffff;
            cy = (cy + $urandom_range(0, 64)) & 16'hffff;
         end
         ncls = $urandom_range(1, 4);
         for (int c = 0; c < ncls; c++) begin
            bit fin;
            bit cut;
            fin = c == ncls - 1;
            cut = fin && a == anchors - 1 && $urandom_range(0, 4) == 0;
            // only the box of the anchor's closing request counts
            send_request(make_request(fin ? cx : $urandom_range(0, 65535), cy, w,
                                      fin ? h : $urandom_range(0, 65535),
                                      $urandom_range(0, 65535), $urandom_range(0, cls_hi),
                                      fin && !cut, a == anchors - 1 && fin));
            budget--;
         end
      end
   endtask

   task automatic test_random_frames();
      int budget;
      int group;
      budget = 230 - 72;
      group = 0;
      while (budget > 0) begin
         if (group % 3 == 0)
            write_all($urandom_range(0, 80), $urandom_range(0, 80),
                      $urandom_range(2048, 9000), $urandom_range(1, 4095),
                      $urandom_range(1, 4095), $urandom_range(0, 40000),
                      $urandom_range(0, 65535));
         if (budget < 40) quiet = 1'b1;
         random_frame($urandom_range(1, 8), budget);
         group++;
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wr_data = '0;
      errors = 0; frames = 0; results_seen = 0; requests_sent = 0;
      quiet = 1'b0;
      pad_x = 0; pad_y = 0; inv_scale = 4096; img_w = 640; img_h = 640;
      score_min = 16384; overlap_min = 29491;
      anchor_score = '0; anchor_class = '0; held_box = '0;
      kept_n = 0; evicted = 1'b0;
      for (int k = 0; k < MAX_KEPT; k++) dropped[k] = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_defaults();
      test_empty_frame();
      test_register_extremes();
      test_store_overflow();
      test_random_frames();
      wait_idle();
      $display("sent %0d requests in %0d frames, checked %0d results",
               requests_sent, frames, results_seen);
      $display("covered register extremes, empty frames and store overflow");
      if (errors == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
design/ddn_pkg.sv
design/detector_decode_and_nms_top.sv
bench/tb_top.sv
